/* src/tmwf_pkg.sv */
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// Trimmed-mean window filter package
// Shared constants, codes, sequencer states and control structs.
// ----------------------------------------------------------------------------
package tmwf_pkg;

    // Window and sample geometry
    localparam int WINDOW_MAX  = 32;
    localparam int WINDOW_MIN  = 3;
    localparam int SAMPLE_BITS = 24;
    localparam int IDX_W       = $clog2(WINDOW_MAX);
    localparam int SIZE_W      = 6;

    // Accumulator: holds the window sum with margin for the trim and negate
    localparam int SUM_W  = SAMPLE_BITS + IDX_W + 1;
    // Magnitude of the trimmed sum, divided one bit per step
    localparam int QUO_W  = SUM_W - 1;
    // Divisor (window size minus two) and remainder width
    localparam int DIV_W  = $clog2(WINDOW_MAX - 1);
    localparam int CNT_W  = (IDX_W > $clog2(QUO_W)) ? IDX_W : $clog2(QUO_W);

    // Configuration port
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = SIZE_W;
    localparam logic [CFG_IDX_W-1:0] CFG_IDX_WINDOW_SIZE = CFG_IDX_W'(0);
    localparam logic [CFG_IDX_W-1:0] CFG_IDX_SMOOTH_EN   = CFG_IDX_W'(1);
    localparam logic [SIZE_W-1:0]    WINDOW_SIZE_RESET   = SIZE_W'(16);
    localparam logic                 SMOOTH_EN_RESET     = 1'b1;

    // Input operation codes
    localparam logic OP_PUSH   = 1'b0;
    localparam logic OP_PRESET = 1'b1;

    typedef enum logic [2:0] {
        S_IDLE,
        S_SCAN,
        S_TRIM_LO,
        S_TRIM_HI,
        S_ABS,
        S_DIV,
        S_SIGN,
        S_DONE
    } t_state;

    typedef enum logic [3:0] {
        DP_NOP,
        DP_LOAD,
        DP_SCAN_FIRST,
        DP_SCAN,
        DP_TRIM_LO,
        DP_TRIM_HI,
        DP_ABS,
        DP_DIV,
        DP_SIGN
    } t_dp_op;

    typedef struct packed {
        t_dp_op             op;
        logic [DIV_W-1:0]   divisor;
    } t_dp_ctrl;

    typedef struct packed {
        logic               push_we;
        logic               preset_we;
        logic [IDX_W-1:0]   rd_idx;
    } t_win_ctrl;

    // Clamp the window size register into the supported range
    function automatic logic [SIZE_W-1:0] clamp_size(input logic [SIZE_W-1:0] v);
        logic [SIZE_W-1:0] r;
        r = v;
        if (v < SIZE_W'(WINDOW_MIN)) begin
            r = SIZE_W'(WINDOW_MIN);
        end else if (v > SIZE_W'(WINDOW_MAX)) begin
            r = SIZE_W'(WINDOW_MAX);
        end
        return r;
    endfunction

endpackage
`default_nettype wire

/* src/tmwf_window.sv */
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// Trimmed-mean window store
// Ring of sample registers with write position, preset fill and one read port.
// ----------------------------------------------------------------------------
module tmwf_window
    import tmwf_pkg::*;
(
    input  wire logic                          i_clk,
    input  wire logic                          i_rst_n,
    input  wire t_win_ctrl                     i_ctrl,
    input  wire logic signed [SAMPLE_BITS-1:0] i_sample,
    input  wire logic [SIZE_W-1:0]             i_size,
    output logic signed [SAMPLE_BITS-1:0]      o_rd_data
);

    logic signed [SAMPLE_BITS-1:0] r_store [WINDOW_MAX];
    logic [IDX_W-1:0]              r_wp;
    logic [IDX_W-1:0]              wr_pos;
    logic [IDX_W-1:0]              n_wp;
    logic [SIZE_W-1:0]             wr_pos_inc;

    // Restart at slot zero if a smaller window leaves the pointer outside
    always_comb begin
        wr_pos     = (SIZE_W'(r_wp) >= i_size) ? '0 : r_wp;
        wr_pos_inc = SIZE_W'(wr_pos) + SIZE_W'(1);
        n_wp       = (wr_pos_inc >= i_size) ? '0 : wr_pos_inc[IDX_W-1:0];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp <= '0;
            for (int k = 0; k < WINDOW_MAX; k++) begin
                r_store[k] <= '0;
            end
        end else if (i_ctrl.preset_we) begin
            r_wp <= '0;
            for (int k = 0; k < WINDOW_MAX; k++) begin
                r_store[k] <= i_sample;
            end
        end else if (i_ctrl.push_we) begin
            r_wp            <= n_wp;
            r_store[wr_pos] <= i_sample;
        end
    end

    assign o_rd_data = r_store[i_ctrl.rd_idx];

endmodule
`default_nettype wire

/* src/tmwf_datapath.sv */
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// Trimmed-mean datapath
// One shared add/subtract unit for sum, trim, negate and restoring divide,
// plus the running minimum and maximum.
// ----------------------------------------------------------------------------
module tmwf_datapath
    import tmwf_pkg::*;
(
    input  wire logic                          i_clk,
    input  wire t_dp_ctrl                      i_ctrl,
    input  wire logic signed [SAMPLE_BITS-1:0] i_entry,
    input  wire logic signed [SAMPLE_BITS-1:0] i_sample,
    output logic [SAMPLE_BITS-1:0]             o_result
);

    logic [SUM_W-1:0]              r_acc;
    logic [SUM_W-1:0]              n_acc;
    logic signed [SAMPLE_BITS-1:0] r_lo;
    logic signed [SAMPLE_BITS-1:0] n_lo;
    logic signed [SAMPLE_BITS-1:0] r_hi;
    logic signed [SAMPLE_BITS-1:0] n_hi;
    logic [DIV_W-1:0]              r_rem;
    logic [DIV_W-1:0]              n_rem;
    logic                          r_neg;
    logic                          n_neg;

    logic [SUM_W-1:0] add_a;
    logic [SUM_W-1:0] add_b;
    logic             add_sub;
    logic [SUM_W-1:0] add_res;
    logic [DIV_W:0]   rem_shift;
    logic [SUM_W-1:0] entry_ext;
    logic [SUM_W-1:0] quo_ext;

    assign entry_ext = {{(SUM_W-SAMPLE_BITS){i_entry[SAMPLE_BITS-1]}}, i_entry};
    assign quo_ext   = {{(SUM_W-QUO_W){1'b0}}, r_acc[QUO_W-1:0]};
    assign rem_shift = {r_rem, r_acc[QUO_W-1]};

    // Shared adder: a + b, or a - b when add_sub is set
    assign add_res = add_a + (add_sub ? ~add_b : add_b) + SUM_W'(add_sub);

    always_comb begin
        add_a   = '0;
        add_b   = '0;
        add_sub = 1'b0;
        n_acc   = r_acc;
        n_lo    = r_lo;
        n_hi    = r_hi;
        n_rem   = r_rem;
        n_neg   = r_neg;
        case (i_ctrl.op)
            DP_LOAD: begin
                n_acc = {{(SUM_W-SAMPLE_BITS){i_sample[SAMPLE_BITS-1]}}, i_sample};
                n_neg = 1'b0;
            end
            DP_SCAN_FIRST: begin
                add_b = entry_ext;
                n_acc = add_res;
                n_lo  = i_entry;
                n_hi  = i_entry;
            end
            DP_SCAN: begin
                add_a = r_acc;
                add_b = entry_ext;
                n_acc = add_res;
                if (i_entry < r_lo) begin
                    n_lo = i_entry;
                end
                if (i_entry > r_hi) begin
                    n_hi = i_entry;
                end
            end
            DP_TRIM_LO: begin
                add_a   = r_acc;
                add_b   = {{(SUM_W-SAMPLE_BITS){r_lo[SAMPLE_BITS-1]}}, r_lo};
                add_sub = 1'b1;
                n_acc   = add_res;
            end
            DP_TRIM_HI: begin
                add_a   = r_acc;
                add_b   = {{(SUM_W-SAMPLE_BITS){r_hi[SAMPLE_BITS-1]}}, r_hi};
                add_sub = 1'b1;
                n_acc   = add_res;
            end
            DP_ABS: begin
                // Take magnitude, remember sign for truncation toward zero
                add_b   = r_acc;
                add_sub = 1'b1;
                n_neg   = r_acc[SUM_W-1];
                n_rem   = '0;
                if (r_acc[SUM_W-1]) begin
                    n_acc = add_res;
                end
            end
            DP_DIV: begin
                // Restoring step: trial subtract, shift in quotient bit
                add_a   = {{(SUM_W-DIV_W-1){1'b0}}, rem_shift};
                add_b   = {{(SUM_W-DIV_W){1'b0}}, i_ctrl.divisor};
                add_sub = 1'b1;
                if (!add_res[SUM_W-1]) begin
                    n_rem = add_res[DIV_W-1:0];
                end else begin
                    n_rem = rem_shift[DIV_W-1:0];
                end
                n_acc = {r_acc[SUM_W-2:0], ~add_res[SUM_W-1]};
            end
            DP_SIGN: begin
                add_b   = quo_ext;
                add_sub = 1'b1;
                n_acc   = r_neg ? add_res : quo_ext;
            end
            default: begin
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        r_acc <= n_acc;
        r_lo  <= n_lo;
        r_hi  <= n_hi;
        r_rem <= n_rem;
        r_neg <= n_neg;
    end

    assign o_result = r_acc[SAMPLE_BITS-1:0];

endmodule
`default_nettype wire

/* src/tmwf_ctrl.sv */
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// Trimmed-mean sequencer
// Steps the shared datapath through scan, trim, divide and hand-off.
// ----------------------------------------------------------------------------
module tmwf_ctrl
    import tmwf_pkg::*;
(
    input  wire logic              i_clk,
    input  wire logic              i_rst_n,
    input  wire logic              i_in_valid,
    input  wire logic              i_op,
    input  wire logic              i_smooth_en,
    input  wire logic [SIZE_W-1:0] i_size,
    input  wire logic              i_out_free,
    output logic                   o_busy,
    output logic                   o_load_out,
    output t_win_ctrl              o_win_ctrl,
    output t_dp_ctrl               o_dp_ctrl,
    output t_state                 o_state
);

    t_state             r_state;
    t_state             n_state;
    logic [CNT_W-1:0]   r_cnt;
    logic [CNT_W-1:0]   n_cnt;
    logic [SIZE_W-1:0]  r_n;
    logic [SIZE_W-1:0]  n_n;
    logic               scan_end;
    logic               div_end;
    logic [SIZE_W-1:0]  divisor_full;

    assign scan_end     = (SIZE_W'(r_cnt) == (r_n - SIZE_W'(1)));
    assign div_end      = (r_cnt == CNT_W'(QUO_W - 1));
    assign divisor_full = r_n - SIZE_W'(2);

    // Next state
    always_comb begin
        n_state = r_state;
        case (r_state)
            S_IDLE: begin
                if (i_in_valid && (i_op == OP_PUSH)) begin
                    n_state = i_smooth_en ? S_SCAN : S_DONE;
                end
            end
            S_SCAN: begin
                if (scan_end) begin
                    n_state = S_TRIM_LO;
                end
            end
            S_TRIM_LO: n_state = S_TRIM_HI;
            S_TRIM_HI: n_state = S_ABS;
            S_ABS:     n_state = S_DIV;
            S_DIV: begin
                if (div_end) begin
                    n_state = S_SIGN;
                end
            end
            S_SIGN:    n_state = S_DONE;
            S_DONE: begin
                if (i_out_free) begin
                    n_state = S_IDLE;
                end
            end
            default:   n_state = S_IDLE;
        endcase
    end

    // Outputs and counters
    always_comb begin
        o_load_out           = 1'b0;
        o_win_ctrl.push_we   = 1'b0;
        o_win_ctrl.preset_we = 1'b0;
        o_win_ctrl.rd_idx    = r_cnt[IDX_W-1:0];
        o_dp_ctrl.op         = DP_NOP;
        o_dp_ctrl.divisor    = divisor_full[DIV_W-1:0];
        n_cnt                = r_cnt;
        n_n                  = r_n;
        case (r_state)
            S_IDLE: begin
                n_cnt = '0;
                if (i_in_valid) begin
                    if (i_op == OP_PRESET) begin
                        o_win_ctrl.preset_we = 1'b1;
                    end else if (i_smooth_en) begin
                        o_win_ctrl.push_we = 1'b1;
                        n_n                = i_size;
                    end else begin
                        o_dp_ctrl.op = DP_LOAD;
                    end
                end
            end
            S_SCAN: begin
                o_dp_ctrl.op = (r_cnt == '0) ? DP_SCAN_FIRST : DP_SCAN;
                n_cnt        = scan_end ? '0 : r_cnt + CNT_W'(1);
            end
            S_TRIM_LO: o_dp_ctrl.op = DP_TRIM_LO;
            S_TRIM_HI: o_dp_ctrl.op = DP_TRIM_HI;
            S_ABS: begin
                o_dp_ctrl.op = DP_ABS;
                n_cnt        = '0;
            end
            S_DIV: begin
                o_dp_ctrl.op = DP_DIV;
                n_cnt        = r_cnt + CNT_W'(1);
            end
            S_SIGN:    o_dp_ctrl.op = DP_SIGN;
            S_DONE:    o_load_out   = i_out_free;
            default: begin
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_cnt   <= '0;
            r_n     <= WINDOW_SIZE_RESET;
        end else begin
            r_state <= n_state;
            r_cnt   <= n_cnt;
            r_n     <= n_n;
        end
    end

    assign o_busy  = (r_state != S_IDLE);
    assign o_state = r_state;

endmodule
`default_nettype wire

/* src/trimmed_mean_window_filter.sv */
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// Trimmed-mean window filter
// Ring window of signed samples; each push returns the window mean with the
// lowest and highest entries dropped, or the raw sample when bypassed.
// ----------------------------------------------------------------------------
//
//  channel | direction | handshake                  | payload
//  --------+-----------+----------------------------+--------------------------
//  in      | sink      | i_in_valid / o_in_stall    | i_op, i_sample
//  out     | source    | o_out_valid / i_out_stall  | o_filtered_value
//  cfg     | sink      | i_cfg_valid / o_cfg_ready  | i_cfg_index, i_cfg_data
//
//  A smoothed push steps through acceptance, a scan of each entry through the
//  shared adder, the low and high trims, the magnitude, 29 restoring-divide
//  steps, the sign and the hand-off, which loads the result register. A
//  bypassed push goes from acceptance straight to the hand-off; a preset
//  completes in its acceptance cycle. The hand-off waits while a stalled
//  result holds the output register. Synchronous active-low reset zeroes the
//  window and the write position and loads window size 16 with smoothing on.
//  The input stalls while a transaction is in flight; a finished result sits
//  in the output register, so the next transaction is taken while that result
//  is stalled.
//
module trimmed_mean_window_filter
    import tmwf_pkg::*;
(
    input  wire logic                          i_clk,
    input  wire logic                          i_rst_n,
    // Input channel
    input  wire logic                          i_in_valid,
    output logic                               o_in_stall,
    input  wire logic                          i_op,
    input  wire logic signed [SAMPLE_BITS-1:0] i_sample,
    // Output channel
    output logic                               o_out_valid,
    input  wire logic                          i_out_stall,
    output logic signed [SAMPLE_BITS-1:0]      o_filtered_value,
    // Configuration channel
    input  wire logic                          i_cfg_valid,
    output logic                               o_cfg_ready,
    input  wire logic [CFG_IDX_W-1:0]          i_cfg_index,
    input  wire logic [CFG_DATA_W-1:0]         i_cfg_data
);

    // Configuration registers
    logic [SIZE_W-1:0] r_window_size;
    logic              r_smooth_en;
    logic [SIZE_W-1:0] size_clamped;

    // Output register
    logic                          r_out_valid;
    logic signed [SAMPLE_BITS-1:0] r_out_data;
    logic                          out_free;

    // Internal links
    logic                          busy;
    logic                          load_out;
    t_win_ctrl                     win_ctrl;
    t_dp_ctrl                      dp_ctrl;
    t_state                        state;
    logic signed [SAMPLE_BITS-1:0] rd_data;
    logic [SAMPLE_BITS-1:0]        dp_result;
    logic                          in_accept;

    // Configuration writes are always taken; unknown indexes are dropped
    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_window_size <= WINDOW_SIZE_RESET;
            r_smooth_en   <= SMOOTH_EN_RESET;
        end else if (i_cfg_valid && o_cfg_ready) begin
            case (i_cfg_index)
                CFG_IDX_WINDOW_SIZE: r_window_size <= i_cfg_data;
                CFG_IDX_SMOOTH_EN:   r_smooth_en   <= i_cfg_data[0];
                default: begin
                end
            endcase
        end
    end

    // Keep the register value as written; clamp only at use
    assign size_clamped = clamp_size(r_window_size);

    assign o_in_stall = busy;
    assign in_accept  = i_in_valid && !o_in_stall;

    // The output register is free when empty or drained this cycle
    assign out_free = !r_out_valid || !i_out_stall;

    tmwf_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .i_op        (i_op),
        .i_smooth_en (r_smooth_en),
        .i_size      (size_clamped),
        .i_out_free  (out_free),
        .o_busy      (busy),
        .o_load_out  (load_out),
        .o_win_ctrl  (win_ctrl),
        .o_dp_ctrl   (dp_ctrl),
        .o_state     (state)
    );

    tmwf_window u_window (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_ctrl    (win_ctrl),
        .i_sample  (i_sample),
        .i_size    (size_clamped),
        .o_rd_data (rd_data)
    );

    tmwf_datapath u_datapath (
        .i_clk    (i_clk),
        .i_ctrl   (dp_ctrl),
        .i_entry  (rd_data),
        .i_sample (i_sample),
        .o_result (dp_result)
    );

    // Hold the result until the sink takes it; refill in the same cycle
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (load_out) begin
            r_out_valid <= 1'b1;
        end else if (!i_out_stall) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (load_out) begin
            r_out_data <= dp_result;
        end
    end

    assign o_out_valid      = r_out_valid;
    assign o_filtered_value = r_out_data;

    // A smoothed push must start the scan on the next cycle
    a_push_starts_scan: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (in_accept && (i_op == OP_PUSH) && r_smooth_en) |=> (state == S_SCAN))
        else $error("smoothed push did not enter scan");

    // A preset completes in its acceptance cycle
    a_preset_no_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (in_accept && (i_op == OP_PRESET)) |=> !o_in_stall)
        else $error("preset left the block busy");

    // A new result appears only after the sequencer finished a transaction
    a_result_from_done: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(r_out_valid) |-> $past(state == S_DONE))
        else $error("output loaded outside hand-off");

    // The divider never runs with a zero divisor
    a_divisor_nonzero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (state == S_DIV) |-> (dp_ctrl.divisor != '0))
        else $error("divide step with zero divisor");

endmodule
`default_nettype wire

/* tb/trimmed_mean_window_filter_tb.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Trimmed-mean window filter testbench
// Drives push and preset transactions through the filter under a series of
// window sizes and smoothing settings, predicts every filtered value with a
// local copy of the ring window, and checks each result in order. Both sides
// throttle at random; one phase holds the receiver off long enough to back the
// filter up, and every phase drains fully before the registers change.
// ----------------------------------------------------------------------------
module trimmed_mean_window_filter_tb;
    import tmwf_pkg::*;

    localparam int CYCLE_LIMIT  = 1_000_000;
    localparam int SETTLE_CYCLES = 100;
    localparam int HOLD_CYCLES  = 400;
    localparam int REPORT_MAX   = 10;

    // Register indexes the block does not decode
    localparam logic [CFG_IDX_W-1:0] CFG_IDX_SPARE_A = CFG_IDX_W'(2);
    localparam logic [CFG_IDX_W-1:0] CFG_IDX_SPARE_B = CFG_IDX_W'(3);

    localparam logic signed [SAMPLE_BITS-1:0] SAMPLE_MAX = {1'b0, {(SAMPLE_BITS-1){1'b1}}};
    localparam logic signed [SAMPLE_BITS-1:0] SAMPLE_MIN = {1'b1, {(SAMPLE_BITS-1){1'b0}}};

    // Sample regimes used to build bursts of pushes
    typedef enum int {
        REG_FULL,
        REG_CLUSTER,
        REG_EXTREME,
        REG_OUTLIER
    } t_regime;

    typedef struct {
        logic                          op;
        logic signed [SAMPLE_BITS-1:0] sample;
    } t_sample_item;

    logic clk = 1'b0;
    logic rst_n = 1'b0;

    logic                          in_valid = 1'b0;
    logic                          in_op = OP_PUSH;
    logic signed [SAMPLE_BITS-1:0] in_sample = '0;
    logic                          out_stall = 1'b0;
    logic                          cfg_valid = 1'b0;
    logic [CFG_IDX_W-1:0]          cfg_index = CFG_IDX_WINDOW_SIZE;
    logic [CFG_DATA_W-1:0]         cfg_data = '0;

    logic                          in_stall;
    logic                          out_valid;
    logic signed [SAMPLE_BITS-1:0] filtered_value;
    logic                          cfg_ready;

    // Stimulus and expectation stores
    t_sample_item                  sample_q[$];
    logic signed [SAMPLE_BITS-1:0] filtered_q[$];

    // Local copy of the filter state and its registers
    logic signed [SAMPLE_BITS-1:0] win_mem [WINDOW_MAX];
    int                            wr_pos;
    logic [SIZE_W-1:0]             cur_size;
    logic                          cur_smooth;

    // Throttle control for driver and receiver, set by sequencer and monitor
    bit  idle_on = 1'b1;
    int  hold_ask = 0;
    int  hold_seen = 0;
    int  hold_left = 0;
    bit  in_taken = 1'b0;

    int  cycle_cnt = 0;
    int  err_cnt = 0;
    int  n_push = 0;
    int  n_preset = 0;
    int  n_checked = 0;
    int  n_settings = 0;

    trimmed_mean_window_filter u_top (
        .i_clk            (clk),
        .i_rst_n          (rst_n),
        .i_in_valid       (in_valid),
        .o_in_stall       (in_stall),
        .i_op             (in_op),
        .i_sample         (in_sample),
        .o_out_valid      (out_valid),
        .i_out_stall      (out_stall),
        .o_filtered_value (filtered_value),
        .i_cfg_valid      (cfg_valid),
        .o_cfg_ready      (cfg_ready),
        .i_cfg_index      (cfg_index),
        .i_cfg_data       (cfg_data)
    );

    always begin
        #1 clk = 1'b1;
        #1 clk = 1'b0;
    end

    // ------------------------------------------------------------------------
    // Filter prediction
    // ------------------------------------------------------------------------

    // Clear the window and load the reset register values
    function automatic void window_clear();
        int i;
        for (i = 0; i < WINDOW_MAX; i++) begin
            win_mem[i] = '0;
        end
        wr_pos     = 0;
        cur_size   = WINDOW_SIZE_RESET;
        cur_smooth = SMOOTH_EN_RESET;
    endfunction

    // Apply one transaction to the window; return 1 when it yields a value
    function automatic bit window_step(input t_sample_item it,
                                       output logic signed [SAMPLE_BITS-1:0] mean);
        int     i;
        int     n;
        longint acc;
        longint lo;
        longint hi;
        longint e;
        mean = '0;
        if (it.op == OP_PRESET) begin
            // Preset covers every slot regardless of the window size
            for (i = 0; i < WINDOW_MAX; i++) begin
                win_mem[i] = it.sample;
            end
            wr_pos = 0;
            return 1'b0;
        end
        if (!cur_smooth) begin
            // Bypass leaves the window and write position alone
            mean = it.sample;
            return 1'b1;
        end
        n = int'(cur_size);
        if (n < WINDOW_MIN) begin
            n = WINDOW_MIN;
        end else if (n > WINDOW_MAX) begin
            n = WINDOW_MAX;
        end
        // A shrunk window can leave the write position past its end
        if (wr_pos >= n) begin
            wr_pos = 0;
        end
        win_mem[wr_pos] = it.sample;
        wr_pos = (wr_pos + 1 >= n) ? 0 : wr_pos + 1;
        acc = 0;
        lo  = win_mem[0];
        hi  = win_mem[0];
        for (i = 0; i < n; i++) begin
            e = win_mem[i];
            if (e < lo) begin
                lo = e;
            end
            if (e > hi) begin
                hi = e;
            end
            acc += e;
        end
        acc = acc - lo - hi;
        // Signed division truncates toward zero
        mean = SAMPLE_BITS'(acc / longint'(n - 2));
        return 1'b1;
    endfunction

    // ------------------------------------------------------------------------
    // Driver: present the next pending transaction at the falling edge
    // ------------------------------------------------------------------------
    always @(negedge clk) begin : drive_proc
        t_sample_item nxt;
        if (!rst_n) begin
            in_valid <= 1'b0;
        end else if (!in_valid || in_taken) begin
            // Advance only once the current transaction has been taken
            if (sample_q.size() != 0 && !(idle_on && $urandom_range(99) < 10)) begin
                nxt = sample_q.pop_front();
                in_valid  <= 1'b1;
                in_op     <= nxt.op;
                in_sample <= nxt.sample;
            end else begin
                in_valid <= 1'b0;
            end
        end
    end

    // ------------------------------------------------------------------------
    // Receiver: random stalls, plus a long hold-off on request
    // ------------------------------------------------------------------------
    always @(negedge clk) begin
        if (hold_ask != hold_seen) begin
            hold_seen <= hold_ask;
            hold_left <= HOLD_CYCLES;
            out_stall <= 1'b1;
        end else if (hold_left != 0) begin
            hold_left <= hold_left - 1;
            out_stall <= 1'b1;
        end else begin
            out_stall <= idle_on && ($urandom_range(99) < 10);
        end
    end

    // ------------------------------------------------------------------------
    // Monitor: check results, predict accepted inputs, track register writes
    // ------------------------------------------------------------------------
    always @(posedge clk) begin : check_proc
        logic signed [SAMPLE_BITS-1:0] want;
        logic signed [SAMPLE_BITS-1:0] mean;
        t_sample_item                  it;
        in_taken <= in_valid && !in_stall;
        if (rst_n) begin
            // Compare the result first; a transaction taken now yields later
            if (out_valid && !out_stall) begin
                n_checked++;
                if (filtered_q.size() == 0) begin
                    err_cnt++;
                    if (err_cnt <= REPORT_MAX) begin
                        $display("[%0t] unexpected result %0d", $realtime, filtered_value);
                    end
                end else begin
                    want = filtered_q.pop_front();
                    if (filtered_value !== want) begin
                        err_cnt++;
                        if (err_cnt <= REPORT_MAX) begin
                            $display("[%0t] filtered_value mismatch: expected %0d, got %0d",
                                     $realtime, want, filtered_value);
                        end
                    end
                end
            end
            if (in_valid && !in_stall) begin
                it.op     = in_op;
                it.sample = in_sample;
                if (in_op == OP_PRESET) begin
                    n_preset++;
                end else begin
                    n_push++;
                end
                if (window_step(it, mean)) begin
                    filtered_q.push_back(mean);
                end
            end
            if (cfg_valid && cfg_ready) begin
                case (cfg_index)
                    CFG_IDX_WINDOW_SIZE: begin
                        cur_size = cfg_data;
                    end
                    CFG_IDX_SMOOTH_EN: begin
                        cur_smooth = cfg_data[0];
                    end
                    default: begin
                        // Undecoded index: drop the write
                    end
                endcase
            end
        end
    end

    // Watchdog
    always @(posedge clk) begin
        cycle_cnt <= cycle_cnt + 1;
        if (cycle_cnt == CYCLE_LIMIT) begin
            $display("TB_ERROR");
            $finish;
        end
    end

    // ------------------------------------------------------------------------
    // Sequencer helpers
    // ------------------------------------------------------------------------

    task automatic queue_item(input logic op, input logic signed [SAMPLE_BITS-1:0] s);
        t_sample_item it;
        it.op     = op;
        it.sample = s;
        sample_q.push_back(it);
    endtask

    // Write one register; the block is idle whenever this is called
    task automatic reg_write(input logic [CFG_IDX_W-1:0] idx,
                             input logic [CFG_DATA_W-1:0] data);
        @(negedge clk);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= data;
        @(posedge clk);
        while (!cfg_ready) begin
            @(posedge clk);
        end
        @(negedge clk);
        cfg_valid <= 1'b0;
    endtask

    // Hold the sender until every expected value is back, then let any
    // trailing preset finish
    task automatic drain();
        while (sample_q.size() != 0 || in_valid || filtered_q.size() != 0) begin
            @(negedge clk);
        end
        repeat (SETTLE_CYCLES) @(negedge clk);
    endtask

    function automatic logic signed [SAMPLE_BITS-1:0] pick_sample(
        input t_regime rg, input logic signed [SAMPLE_BITS-1:0] base);
        logic signed [SAMPLE_BITS-1:0] s;
        case (rg)
            REG_CLUSTER: begin
                s = base + SAMPLE_BITS'($urandom_range(30)) - SAMPLE_BITS'(15);
            end
            REG_EXTREME: begin
                case ($urandom_range(4))
                    0:       s = SAMPLE_MAX;
                    1:       s = SAMPLE_MIN;
                    2:       s = '0;
                    3:       s = '1;
                    default: s = SAMPLE_BITS'(1);
                endcase
            end
            REG_OUTLIER: begin
                s = ($urandom_range(9) == 0) ? SAMPLE_BITS'($urandom) : base;
            end
            default: begin
                s = SAMPLE_BITS'($urandom);
            end
        endcase
        return s;
    endfunction

    // Set both registers, queue a run of bursts, and drain
    task automatic run_phase(input logic [SIZE_W-1:0] size_val, input logic smooth_val,
                             input int n_items, input bit quiet, input bit hold);
        logic [CFG_DATA_W-1:0]         smooth_word;
        logic signed [SAMPLE_BITS-1:0] base;
        t_regime                       rg;
        int                            burst;
        int                            k;
        smooth_word    = CFG_DATA_W'($urandom);
        smooth_word[0] = smooth_val;
        reg_write(CFG_IDX_WINDOW_SIZE, size_val);
        reg_write(CFG_IDX_SMOOTH_EN, smooth_word);
        n_settings++;
        idle_on <= !quiet;
        if (hold) begin
            hold_ask <= hold_ask + 1;
        end
        burst = 0;
        rg    = REG_FULL;
        base  = '0;
        for (k = 0; k < n_items; k++) begin
            if (burst == 0) begin
                // Start a fresh burst, two in five of them from a preset window
                burst = $urandom_range(8, 24);
                rg    = t_regime'($urandom_range(3));
                base  = SAMPLE_BITS'($urandom);
                if ($urandom_range(99) < 40) begin
                    queue_item(OP_PRESET, pick_sample(rg, base));
                    k++;
                end
            end
            if ($urandom_range(99) < 3) begin
                queue_item(OP_PRESET, SAMPLE_BITS'($urandom));
            end else begin
                queue_item(OP_PUSH, pick_sample(rg, base));
            end
            burst--;
        end
        drain();
    endtask

    // ------------------------------------------------------------------------
    // Sequence
    // ------------------------------------------------------------------------
    initial begin : seq_proc
        int p;
        window_clear();
        repeat (4) @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        // Directed transactions under the reset settings (16 entries, smoothed)
        queue_item(OP_PUSH, SAMPLE_MAX);
        queue_item(OP_PUSH, SAMPLE_MIN);
        queue_item(OP_PUSH, '0);
        queue_item(OP_PUSH, '1);
        queue_item(OP_PUSH, SAMPLE_BITS'(1));
        // Full window at the minimum, one maximum trimmed away
        queue_item(OP_PRESET, SAMPLE_MIN);
        queue_item(OP_PUSH, SAMPLE_MAX);
        queue_item(OP_PUSH, SAMPLE_MIN);
        queue_item(OP_PRESET, SAMPLE_MAX);
        queue_item(OP_PUSH, SAMPLE_MIN);
        queue_item(OP_PUSH, SAMPLE_MAX);
        // Small negative sums: check truncation toward zero
        queue_item(OP_PRESET, '0);
        queue_item(OP_PUSH, '1);
        queue_item(OP_PUSH, -SAMPLE_BITS'(7));
        queue_item(OP_PUSH, -SAMPLE_BITS'(20));
        queue_item(OP_PUSH, SAMPLE_BITS'(5));
        queue_item(OP_PUSH, -SAMPLE_BITS'(3));
        queue_item(OP_PRESET, SAMPLE_BITS'(100));
        queue_item(OP_PUSH, SAMPLE_BITS'(101));
        queue_item(OP_PUSH, SAMPLE_BITS'(99));
        drain();

        // Undecoded indexes must leave both registers alone
        reg_write(CFG_IDX_SPARE_A, CFG_DATA_W'($urandom));
        reg_write(CFG_IDX_SPARE_B, CFG_DATA_W'($urandom));
        queue_item(OP_PUSH, SAMPLE_BITS'($urandom));
        drain();

        run_phase(SIZE_W'(3),  1'b1, 100, 1'b0, 1'b0);
        run_phase(SIZE_W'(32), 1'b1, 100, 1'b1, 1'b0);   // no throttling at all
        run_phase(SIZE_W'(0),  1'b1, 100, 1'b0, 1'b0);   // clamps up, wraps early
        run_phase(SIZE_W'(63), 1'b1, 100, 1'b0, 1'b0);   // clamps down
        run_phase(SIZE_W'(2),  1'b1,  80, 1'b0, 1'b0);
        run_phase(SIZE_W'(33), 1'b0,  80, 1'b0, 1'b0);   // bypass
        run_phase(SIZE_W'(5),  1'b1, 100, 1'b0, 1'b1);   // receiver backs up
        run_phase(SIZE_W'(1),  1'b1,  80, 1'b0, 1'b0);
        run_phase(SIZE_W'(16), 1'b0,  60, 1'b0, 1'b0);
        run_phase(SIZE_W'(20), 1'b1, 100, 1'b0, 1'b0);
        for (p = 0; p < 3; p++) begin
            run_phase(SIZE_W'($urandom), 1'($urandom), 100, 1'b0, 1'b0);
        end

        $display("Covered %0d pushes and %0d presets over %0d register settings,",
                 n_push, n_preset, n_settings);
        $display("with %0d filtered values checked in %0d cycles.", n_checked, cycle_cnt);
        if (err_cnt == 0) begin
            $display("TB_OK");
        end else begin
            $display("TB_ERROR");
        end
        $finish;
    end

endmodule
